FILE: design/segmentation_argmax_colorizer_defines.svh
// Assertion macros shared by the design files. Both sample on the rising
// edge of clk and are disabled while arst_n is low.
`ifndef SEGMENTATION_ARGMAX_COLORIZER_DEFINES_SVH
`define SEGMENTATION_ARGMAX_COLORIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/sac_pkg.sv
package sac_pkg;

	localparam int MAX_PIXELS  = 65536;
	localparam int MAX_CLASSES = 64;

	localparam int PIX_W  = $clog2(MAX_PIXELS);
	localparam int PIXC_W = PIX_W + 1;
	localparam int CLS_W  = $clog2(MAX_CLASSES);
	localparam int CLSC_W = CLS_W + 1;

	localparam int SCORE_W   = 32;
	localparam int COLOR_W   = 24;
	localparam int BYTE_W    = 8;
	localparam int PAL_W     = 6;
	localparam int PAL_DEPTH = 1 << PAL_W;

	localparam int CFG_NCLS_W = 7;
	localparam int CFG_NPIX_W = 17;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [CFG_NCLS_W-1:0] NCLS_RESET = CFG_NCLS_W'(21);
	localparam logic [CFG_NPIX_W-1:0] NPIX_RESET = CFG_NPIX_W'(65536);

	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_SCORE   = 1'b1;

	typedef enum logic [0:0] {
		REG_NUM_CLASSES = 1'b0,
		REG_NUM_PIXELS  = 1'b1
	} reg_idx_t;

	// One entry of the per-pixel running best.
	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [PAL_W-1:0]          cls;
	} best_t;

endpackage

FILE: design/sac_in_if.sv
interface sac_in_if import sac_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [SCORE_W-1:0] score;
	logic [PAL_W-1:0]          palette_index;
	logic [COLOR_W-1:0]        palette_color;

	modport source (output valid, kind, score, palette_index, palette_color, input ready);
	modport sink (input valid, kind, score, palette_index, palette_color, output ready);
endinterface

FILE: design/sac_out_if.sv
interface sac_out_if import sac_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PAL_W-1:0]  class_index;
	logic [BYTE_W-1:0] blue;
	logic [BYTE_W-1:0] green;
	logic [BYTE_W-1:0] red;
	logic              last_pixel;

	modport source (output valid, class_index, blue, green, red, last_pixel, input ready);
	modport sink (input valid, class_index, blue, green, red, last_pixel, output ready);
endinterface

FILE: design/sac_ram.sv
module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/segmentation_argmax_colorizer.sv
// Channel   Direction  Handshake        Word
// samples   in         valid/ready      kind, score, palette_index, palette_color
// results   out        valid/ready      class_index, blue, green, red, last_pixel
// apb       in         psel/penable     num_classes at 0x0, num_pixels at 0x4
//
// One sample word is taken per unstalled clock; a result passes stages 1 and 2
// and the output register. The rate is set by the read-modify-write of the score
// memory: one read and one write port, one pixel per cycle, with forwarding.
// After reset the block runs at once: the score memory needs no clearing pass
// and the palette reads as zero through 64 valid bits cleared by reset.
// A stalled result holds the pipeline only once a second result reaches the
// stage in front of the output register.
`include "segmentation_argmax_colorizer_defines.svh"

module segmentation_argmax_colorizer import sac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sac_in_if.sink            samples,
	sac_out_if.source         results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Zero counts behave as one, oversized counts saturate at the maximum.
	function automatic logic [CLSC_W-1:0] clamp_ncls(input logic [CFG_NCLS_W-1:0] v);
		logic [CLSC_W-1:0] r;
		if (v == '0) begin
			r = CLSC_W'(1);
		end else if (int'(v) > MAX_CLASSES) begin
			r = CLSC_W'(MAX_CLASSES);
		end else begin
			r = CLSC_W'(v);
		end
		return r;
	endfunction

	function automatic logic [PIXC_W-1:0] clamp_npix(input logic [CFG_NPIX_W-1:0] v);
		logic [PIXC_W-1:0] r;
		if (v == '0) begin
			r = PIXC_W'(1);
		end else if (int'(v) > MAX_PIXELS) begin
			r = PIXC_W'(MAX_PIXELS);
		end else begin
			r = PIXC_W'(v);
		end
		return r;
	endfunction

	// Configuration registers. The raw values are kept for readback, the
	// clamped ones drive the frame counters.
	logic [CFG_NCLS_W-1:0] ncls_raw_q;
	logic [CFG_NPIX_W-1:0] npix_raw_q;
	logic [CLSC_W-1:0]     ncls_q;
	logic [PIXC_W-1:0]     npix_q;
	logic                  cfg_we;
	reg_idx_t              cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (cfg_idx)
			REG_NUM_CLASSES: prdata = APB_DW'(ncls_raw_q);
			REG_NUM_PIXELS:  prdata = APB_DW'(npix_raw_q);
			default:         prdata = '0;
		endcase
	end

	// Frame position of the next score sample.
	logic [PIX_W-1:0] pix_q;
	logic [CLS_W-1:0] ch_q;
	logic             last_px_now;
	logic             last_ch_now;

	assign last_px_now = (({1'b0, pix_q} + PIXC_W'(1)) == npix_q);
	assign last_ch_now = (({1'b0, ch_q} + CLSC_W'(1)) == ncls_q);

	// Pipeline control. The whole pipeline moves together; it stops only when
	// a result sits in front of an output register that is full and not taken.
	logic v_s1;
	logic v_s2;
	logic out_v_q;
	logic adv;
	logic acc;
	logic is_score;

	assign adv           = !(v_s2 && out_v_q && !results.ready);
	assign samples.ready = adv;
	assign acc           = samples.valid && adv;
	assign is_score      = (samples.kind == KIND_SCORE);

	// Stage 1 registers: the accepted word, its frame position, and the
	// forwarded entry if the previous word wrote the same pixel.
	logic                      kind_s1;
	logic signed [SCORE_W-1:0] score_s1;
	logic [PAL_W-1:0]          pidx_s1;
	logic [COLOR_W-1:0]        pcol_s1;
	logic [PIX_W-1:0]          addr_s1;
	logic [CLS_W-1:0]          ch_s1;
	logic                      ch0_s1;
	logic                      lastch_s1;
	logic                      lastpx_s1;
	logic                      fwd_s1;
	best_t                     fwd_data_s1;

	// Score memory: one entry per pixel, read at acceptance, written in stage 1.
	best_t sc_rdata;
	best_t sc_wdata;
	best_t old_best;
	logic  sc_we;
	logic  greater;

	sac_ram #(
		.WIDTH ($bits(best_t)),
		.DEPTH (MAX_PIXELS)
	) u_score_ram (
		.clk   (clk),
		.we    (sc_we),
		.waddr (addr_s1),
		.wdata (sc_wdata),
		.re    (acc),
		.raddr (pix_q),
		.rdata (sc_rdata)
	);

	always_comb begin
		old_best = fwd_s1 ? fwd_data_s1 : sc_rdata;
		greater  = (score_s1 > old_best.score);
		sc_wdata = old_best;
		if (ch0_s1) begin
			// The first plane seeds the pixel with class zero.
			sc_wdata.score = score_s1;
			sc_wdata.cls   = '0;
		end else if (greater) begin
			// Strictly greater only: a tie keeps the lower class.
			sc_wdata.score = score_s1;
			sc_wdata.cls   = PAL_W'(ch_s1);
		end
	end

	assign sc_we = adv && v_s1 && (kind_s1 == KIND_SCORE);

	// Palette memory. Writes and lookups both happen as a word leaves stage 1,
	// so they stay in arrival order. Unwritten entries read as zero.
	logic [PAL_DEPTH-1:0] pal_vld_q;
	logic [COLOR_W-1:0]   pal_rdata;
	logic                 pal_we;
	logic                 pal_re;

	assign pal_we = adv && v_s1 && (kind_s1 == KIND_PALETTE);
	assign pal_re = sc_we;

	sac_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PAL_DEPTH)
	) u_palette_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pidx_s1),
		.wdata (pcol_s1),
		.re    (pal_re),
		.raddr (sc_wdata.cls),
		.rdata (pal_rdata)
	);

	// Stage 2 registers: the winning class of a pixel in the last plane.
	logic [PAL_W-1:0] cls_s2;
	logic             lastpx_s2;
	logic             palv_s2;

	// Output register.
	logic [PAL_W-1:0]   cls_q;
	logic [COLOR_W-1:0] color_q;
	logic               lastpx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncls_raw_q <= NCLS_RESET;
			npix_raw_q <= NPIX_RESET;
			ncls_q     <= clamp_ncls(NCLS_RESET);
			npix_q     <= clamp_npix(NPIX_RESET);
			pix_q      <= '0;
			ch_q       <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			out_v_q    <= 1'b0;
			pal_vld_q  <= '0;
		end else begin
			if (cfg_we) begin
				// Any write restarts the frame.
				unique case (cfg_idx)
					REG_NUM_CLASSES: begin
						ncls_raw_q <= pwdata[CFG_NCLS_W-1:0];
						ncls_q     <= clamp_ncls(pwdata[CFG_NCLS_W-1:0]);
					end
					REG_NUM_PIXELS: begin
						npix_raw_q <= pwdata[CFG_NPIX_W-1:0];
						npix_q     <= clamp_npix(pwdata[CFG_NPIX_W-1:0]);
					end
					default: begin
					end
				endcase
				pix_q <= '0;
				ch_q  <= '0;
			end else if (acc && is_score) begin
				if (last_px_now) begin
					pix_q <= '0;
					ch_q  <= last_ch_now ? '0 : ch_q + CLS_W'(1);
				end else begin
					pix_q <= pix_q + PIX_W'(1);
				end
			end

			if (adv) begin
				v_s1 <= acc;
				v_s2 <= sc_we && lastch_s1;
			end

			if (pal_we) begin
				pal_vld_q[pidx_s1] <= 1'b1;
			end

			if (v_s2 && adv) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1     <= samples.kind;
			score_s1    <= samples.score;
			pidx_s1     <= samples.palette_index;
			pcol_s1     <= samples.palette_color;
			addr_s1     <= pix_q;
			ch_s1       <= ch_q;
			ch0_s1      <= (ch_q == '0);
			lastch_s1   <= last_ch_now;
			lastpx_s1   <= last_px_now;
			// The memory returns the old entry when it is read and written in
			// the same cycle, so the fresh entry is carried along instead.
			fwd_s1      <= sc_we && (addr_s1 == pix_q);
			fwd_data_s1 <= sc_wdata;

			cls_s2      <= sc_wdata.cls;
			lastpx_s2   <= lastpx_s1;
			palv_s2     <= pal_vld_q[sc_wdata.cls];
		end
		if (v_s2 && adv) begin
			cls_q    <= cls_s2;
			color_q  <= palv_s2 ? pal_rdata : '0;
			lastpx_q <= lastpx_s2;
		end
	end

	assign results.valid       = out_v_q;
	assign results.class_index = cls_q;
	assign results.blue        = color_q[BYTE_W-1:0];
	assign results.green       = color_q[2*BYTE_W-1:BYTE_W];
	assign results.red         = color_q[3*BYTE_W-1:2*BYTE_W];
	assign results.last_pixel  = lastpx_q;

	`SAC_ASSERT_SAME(a_stall_cause, !samples.ready, results.valid && !results.ready && v_s2,
		"input stalled without a blocked result")
	`SAC_ASSERT_NEXT(a_s2_hold, v_s2 && !adv, v_s2 && $stable(cls_s2) && $stable(lastpx_s2),
		"stage 2 result moved during a stall")
	`SAC_ASSERT_NEXT(a_frame_wrap, acc && is_score && last_px_now && !cfg_we, pix_q == '0,
		"pixel counter did not wrap at the end of a plane")
	`SAC_ASSERT_NEXT(a_pal_valid, pal_we, pal_vld_q[$past(pidx_s1)],
		"palette entry not marked valid after a load")

endmodule
